/* rtl/core/bdh_pkg.sv */
// ---------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debounce and hold detector.
// ---------------------------------------------------------------------------
package bdh_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS     = 2'd1;
  localparam logic [1:0] CFG_PRESSED_LEVEL  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd60;
  localparam logic [15:0] HOLD_TICKS_RST     = 16'd1200;
  localparam logic        PRESSED_LEVEL_RST  = 1'b1;

  // Timer saturation limits
  localparam logic [15:0] DEB_MAX  = 16'hFFFF;
  localparam logic [16:0] HOLD_MAX = 17'h1FFFF;

  // Per-tick result
  typedef struct packed {
    logic click_taken;
    logic hold_taken;
    logic is_pressed;
    logic is_holding;
    logic click_pending;
    logic hold_pending;
  } bdh_result_t;

  // Configuration seen by the core
  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic        pressed_level;
  } bdh_cfg_t;

endpackage

/* rtl/core/bdh_core.sv */
// ---------------------------------------------------------------------------
// bdh_core
// Debounce and hold state with the single-tick update logic. The state
// advances by one tick whenever step is high; the result of that tick is
// presented combinationally for the caller to register.
// ---------------------------------------------------------------------------
module bdh_core
  import bdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        raw_level,
  input  logic        enabled,
  input  logic        consume_event,
  input  bdh_cfg_t    cfg,
  output bdh_result_t res
);

  logic        lvl_r,   lvl_nxt;
  logic        drun_r,  drun_nxt;
  logic [15:0] dcnt_r,  dcnt_nxt;
  logic        htim_r,  htim_nxt;
  logic [16:0] hcnt_r,  hcnt_nxt;
  logic        hdet_r,  hdet_nxt;
  logic        click_r, click_nxt;
  logic        holdp_r, holdp_nxt;
  logic        click_tk, hold_tk;

  // One tick: advance timers, sample, then serve a consume request
  always_comb begin
    lvl_nxt   = lvl_r;
    drun_nxt  = drun_r;
    htim_nxt  = htim_r;
    hdet_nxt  = hdet_r;
    click_nxt = click_r;
    holdp_nxt = holdp_r;
    click_tk  = 1'b0;
    hold_tk   = 1'b0;

    // timers run on wall time, saturating
    dcnt_nxt = (drun_r && dcnt_r != DEB_MAX) ? dcnt_r + 16'd1 : dcnt_r;
    hcnt_nxt = (htim_r && hcnt_r != HOLD_MAX) ? hcnt_r + 17'd1 : hcnt_r;

    // sampling is frozen while an event is pending
    if (enabled && !click_r && !holdp_r) begin
      if (raw_level == lvl_r) begin
        drun_nxt = 1'b0;
        dcnt_nxt = '0;
        if (htim_r && hcnt_nxt > {1'b0, cfg.hold_ticks}) begin
          hdet_nxt  = 1'b1;
          holdp_nxt = 1'b1;
          htim_nxt  = 1'b0;
          hcnt_nxt  = '0;
        end
      end else if (!drun_r) begin
        drun_nxt = 1'b1;
        dcnt_nxt = '0;
      end else if (dcnt_nxt >= cfg.debounce_ticks) begin
        // level change accepted
        drun_nxt  = 1'b0;
        dcnt_nxt  = '0;
        lvl_nxt   = raw_level;
        holdp_nxt = 1'b0;
        hdet_nxt  = 1'b0;
        hcnt_nxt  = '0;
        if (raw_level == cfg.pressed_level) begin
          htim_nxt = 1'b1;
        end else begin
          click_nxt = 1'b1;
          htim_nxt  = 1'b0;
        end
      end
    end

    // consume: click has priority over hold
    if (consume_event) begin
      if (click_nxt) begin
        click_nxt = 1'b0;
        click_tk  = 1'b1;
      end else if (holdp_nxt) begin
        holdp_nxt = 1'b0;
        htim_nxt  = 1'b0;
        hcnt_nxt  = '0;
        hold_tk   = 1'b1;
      end
    end
  end

  assign res.click_taken   = click_tk;
  assign res.hold_taken    = hold_tk;
  assign res.is_pressed    = (lvl_nxt == cfg.pressed_level);
  assign res.is_holding    = hdet_nxt;
  assign res.click_pending = click_nxt;
  assign res.hold_pending  = holdp_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= 1'b0;
      drun_r  <= 1'b0;
      dcnt_r  <= '0;
      htim_r  <= 1'b0;
      hcnt_r  <= '0;
      hdet_r  <= 1'b0;
      click_r <= 1'b0;
      holdp_r <= 1'b0;
    end else if (step) begin
      lvl_r   <= lvl_nxt;
      drun_r  <= drun_nxt;
      dcnt_r  <= dcnt_nxt;
      htim_r  <= htim_nxt;
      hcnt_r  <= hcnt_nxt;
      hdet_r  <= hdet_nxt;
      click_r <= click_nxt;
      holdp_r <= holdp_nxt;
    end
  end

endmodule

/* rtl/core/button_debounce_hold_detect.sv */
// ---------------------------------------------------------------------------
// button_debounce_hold_detect
// Push-button debouncer with long-press detection and click/hold events.
// ---------------------------------------------------------------------------
// Each input transfer is one time tick carrying the raw pin level, an enable
// and a consume request; each tick yields exactly one result transfer with
// the events taken and the status after that tick. Ticks pass through an
// input register and a result register, so a tick can be accepted every
// clock while the output is not stalled; the debounce and hold state is
// updated as a tick moves from the input register into the result register.
// Configuration (debounce_ticks, hold_ticks, pressed_level) is written over
// the cfg_ port, which is always ready; write it only while the block is idle.
// ---------------------------------------------------------------------------
module button_debounce_hold_detect
  import bdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_raw_level,
  input  logic        in_enabled,
  input  logic        in_consume_event,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_click_taken,
  output logic        out_hold_taken,
  output logic        out_is_pressed,
  output logic        out_is_holding,
  output logic        out_click_pending,
  output logic        out_hold_pending
);

  bdh_cfg_t    cfg_r;
  logic        iv_r;
  logic        raw_r, en_r, cons_r;
  logic        ov_r;
  bdh_result_t res, res_r;
  logic        out_adv;
  logic        in_adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_TICKS_RST;
      cfg_r.hold_ticks     <= HOLD_TICKS_RST;
      cfg_r.pressed_level  <= PRESSED_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_data;
        CFG_HOLD_TICKS:     cfg_r.hold_ticks     <= cfg_data;
        CFG_PRESSED_LEVEL:  cfg_r.pressed_level  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: result stage frees when empty or taken
  assign out_adv  = !ov_r || !out_stall;
  assign in_adv   = !iv_r || out_adv;
  assign in_stall = !in_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_adv) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      raw_r  <= in_raw_level;
      en_r   <= in_enabled;
      cons_r <= in_consume_event;
    end
  end

  // Tick update
  bdh_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (iv_r && out_adv),
    .raw_level     (raw_r),
    .enabled       (en_r),
    .consume_event (cons_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_adv) begin
      ov_r <= iv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && iv_r) begin
      res_r <= res;
    end
  end

  assign out_valid         = ov_r;
  assign out_click_taken   = res_r.click_taken;
  assign out_hold_taken    = res_r.hold_taken;
  assign out_is_pressed    = res_r.is_pressed;
  assign out_is_holding    = res_r.is_holding;
  assign out_click_pending = res_r.click_pending;
  assign out_hold_pending  = res_r.hold_pending;

endmodule
